[src/cbd_pkg.sv]
// Package for the chunked body decoder: size width, ASCII codes, status codes
// and the result record passed from the parser to the output stage.
// No dependencies.
`default_nettype none

package cbd_pkg;

    // Width of the chunk size accumulator and the remaining-byte counter
    localparam int SIZE_BITS = 32;

    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_HT    = 8'h09;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_cbd_status;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        final_result;
        t_cbd_status decode_status;
    } t_cbd_result;

endpackage

`default_nettype wire

[src/cbd_parser.sv]
// Chunk framing parser: size line, payload and trailer phases, one byte per
// accepted item; produces the result record combinationally.
// Depends on cbd_pkg.
`default_nettype none

module cbd_parser import cbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_body,
    output t_cbd_result      o_result,
    output logic             o_has_result
);

    typedef enum logic [2:0] {
        PH_WS       = 3'd0,
        PH_DIGITS   = 3'd1,
        PH_REST_OK  = 3'd2,
        PH_REST_BAD = 3'd3,
        PH_DATA     = 3'd4,
        PH_TRAILER  = 3'd5,
        PH_DONE     = 3'd6,
        PH_FAILED   = 3'd7
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex_digit;

    function automatic t_hex_digit hex_decode(input logic [7:0] b);
        t_hex_digit h;
        h.ok  = 1'b0;
        h.val = b[3:0];
        if (b >= 8'h30 && b <= 8'h39) begin
            h.ok = 1'b1;
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            h.ok  = 1'b1;
            h.val = b[3:0] + 4'd9;
        end
        return h;
    endfunction

    t_phase                 r_phase, n_phase;
    logic [SIZE_BITS-1:0]   r_size_acc, n_size_acc;
    logic [SIZE_BITS-1:0]   r_remaining, n_remaining;
    logic                   r_pend_cr, n_pend_cr;
    logic                   r_size_ovf, n_size_ovf;
    logic [1:0]             r_trailer_cnt, n_trailer_cnt;

    t_hex_digit             digit;
    logic                   is_space;
    logic                   acc_top_busy;
    logic                   pay_valid;
    t_cbd_status            status;

    assign digit        = hex_decode(i_data_byte);
    assign is_space     = (i_data_byte == ASCII_SPACE) ||
                          (i_data_byte >= ASCII_HT && i_data_byte <= ASCII_CR);
    // another digit would overflow the accumulator
    assign acc_top_busy = (r_size_acc[SIZE_BITS-1 -: 4] != 4'd0);

    always_comb begin
        n_phase       = r_phase;
        n_size_acc    = r_size_acc;
        n_remaining   = r_remaining;
        n_pend_cr     = r_pend_cr;
        n_size_ovf    = r_size_ovf;
        n_trailer_cnt = r_trailer_cnt;
        pay_valid     = 1'b0;

        unique case (r_phase)
            PH_WS, PH_DIGITS, PH_REST_OK, PH_REST_BAD: begin
                if (r_pend_cr && i_data_byte == ASCII_LF) begin
                    n_pend_cr = 1'b0;
                    priority if (r_phase == PH_WS || r_phase == PH_REST_BAD || r_size_ovf) begin
                        n_phase = PH_FAILED;
                    end else if (r_size_acc == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_remaining = r_size_acc;
                        n_phase     = PH_DATA;
                    end
                end else begin
                    // a held CR that is not followed by LF ends a digit run
                    if (r_pend_cr && r_phase == PH_DIGITS) begin
                        n_phase = PH_REST_OK;
                    end
                    n_pend_cr = (i_data_byte == ASCII_CR);
                    if (i_data_byte != ASCII_CR) begin
                        priority if (n_phase == PH_WS) begin
                            if (!is_space) begin
                                if (digit.ok) begin
                                    n_phase = PH_DIGITS;
                                    if (acc_top_busy) begin
                                        n_size_ovf = 1'b1;
                                    end else begin
                                        n_size_acc = {r_size_acc[SIZE_BITS-5:0], digit.val};
                                    end
                                end else begin
                                    n_phase = PH_REST_BAD;
                                end
                            end
                        end else if (n_phase == PH_DIGITS) begin
                            if (digit.ok) begin
                                if (!r_size_ovf) begin
                                    if (acc_top_busy) begin
                                        n_size_ovf = 1'b1;
                                    end else begin
                                        n_size_acc = {r_size_acc[SIZE_BITS-5:0], digit.val};
                                    end
                                end
                            end else begin
                                n_phase = PH_REST_OK;
                            end
                        end else begin
                            n_phase = n_phase;
                        end
                    end
                end
            end
            PH_DATA: begin
                pay_valid   = 1'b1;
                n_remaining = r_remaining - 1'b1;
                if (r_remaining == SIZE_BITS'(1)) begin
                    n_phase       = PH_TRAILER;
                    n_trailer_cnt = 2'd2;
                end
            end
            PH_TRAILER: begin
                if (r_trailer_cnt != 2'd0) begin
                    n_trailer_cnt = r_trailer_cnt - 1'b1;
                end
                if (r_trailer_cnt <= 2'd1) begin
                    n_phase       = PH_WS;
                    n_size_acc    = '0;
                    n_size_ovf    = 1'b0;
                    n_pend_cr     = 1'b0;
                    n_trailer_cnt = 2'd0;
                end
            end
            PH_DONE, PH_FAILED: begin
                n_phase = r_phase;
            end
        endcase

        status = ST_OK;
        if (i_end_of_body) begin
            priority if (n_phase == PH_FAILED) begin
                status = ST_MALFORMED;
            end else if (n_phase == PH_DATA && n_remaining != '0) begin
                status = ST_TRUNCATED;
            end else begin
                status = ST_OK;
            end
        end
    end

    assign o_has_result           = pay_valid || i_end_of_body;
    assign o_result.payload_byte  = pay_valid ? i_data_byte : 8'd0;
    assign o_result.payload_valid = pay_valid;
    assign o_result.final_result  = i_end_of_body;
    assign o_result.decode_status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WS;
            r_size_acc    <= '0;
            r_remaining   <= '0;
            r_pend_cr     <= 1'b0;
            r_size_ovf    <= 1'b0;
            r_trailer_cnt <= 2'd0;
        end else if (i_accept) begin
            if (i_end_of_body) begin
                // body finished: back to a fresh start for the next body
                r_phase       <= PH_WS;
                r_size_acc    <= '0;
                r_remaining   <= '0;
                r_pend_cr     <= 1'b0;
                r_size_ovf    <= 1'b0;
                r_trailer_cnt <= 2'd0;
            end else begin
                r_phase       <= n_phase;
                r_size_acc    <= n_size_acc;
                r_remaining   <= n_remaining;
                r_pend_cr     <= n_pend_cr;
                r_size_ovf    <= n_size_ovf;
                r_trailer_cnt <= n_trailer_cnt;
            end
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remaining != '0)
        else $error("data phase with no bytes owed");

    a_trailer_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRAILER |-> (r_trailer_cnt == 2'd1 || r_trailer_cnt == 2'd2))
        else $error("trailer phase with bad skip count");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_body |=> r_phase == PH_WS && !r_pend_cr && r_size_acc == '0)
        else $error("parser not restarted after final item");

endmodule

`default_nettype wire

[src/chunked_body_decoder_unit.sv]
// Top level of the chunked body decoder: parser plus a two-entry output
// register (main + skid) toward the result channel.
// Depends on cbd_pkg and cbd_parser.
//
//   channel | direction | handshake                   | fields
//   --------+-----------+-----------------------------+-----------------------------------
//   in      | input     | i_in_valid / o_in_stall     | i_data_byte, i_end_of_body
//   out     | output    | o_out_valid / i_out_stall   | o_payload_byte, o_payload_valid,
//           |           |                             | o_final_result, o_decode_status
//
// One byte item per cycle while o_in_stall is low; its result (if any) is registered in the
// output register, or in the skid register if the output is stalled. Rate is set by the
// parser state update, a single pass per byte. Items producing neither a payload byte nor
// a final flag give no result. o_in_stall rises only when both the output and skid registers are full.
// Reset is synchronous, active low, and returns the parser to a new body.
`default_nettype none

module chunked_body_decoder_unit import cbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_body,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_valid,
    output logic             o_final_result,
    output logic [1:0]       o_decode_status
);

    t_cbd_result  parse_res;
    logic         has_result;
    logic         in_accept;
    logic         push;
    logic         pop;

    t_cbd_result  r_out;
    logic         r_out_valid;
    t_cbd_result  r_skid;
    logic         r_skid_valid;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign push       = in_accept && has_result;
    assign pop        = r_out_valid && !i_out_stall;

    cbd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_body (i_end_of_body),
        .o_result      (parse_res),
        .o_has_result  (has_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled here, so no new item can arrive
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= push;
            if (push) begin
                r_out <= parse_res;
            end
        end else if (push) begin
            r_skid       <= parse_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_valid = r_out.payload_valid;
    assign o_final_result  = r_out.final_result;
    assign o_decode_status = r_out.decode_status;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !r_skid_valid && !push |=> !r_out_valid)
        else $error("output register kept an item after it was taken");

    a_stalled_push_skids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && push |=> r_skid_valid && r_out_valid)
        else $error("result lost while output was stalled");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for chunked_body_decoder_unit: a directed table of body bytes,
// then random chunked bodies, checked against an in-bench chunked decoding predictor.
// Depends on cbd_pkg and the decoder RTL only.
module tb_top;
    import cbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int ITEM_TARGET = 750;

    typedef enum logic [2:0] {
        LINE_LEAD,
        LINE_SIZE,
        LINE_EXT,
        LINE_JUNK,
        CHUNK_DATA,
        CHUNK_TRAILER,
        BODY_DONE,
        BODY_BAD
    } t_parse_phase;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eob;
        logic        typed;
        t_cbd_result want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_body = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_payload_byte;
    logic       o_payload_valid;
    logic       o_final_result;
    logic [1:0] o_decode_status;

    chunked_body_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_body   (i_end_of_body),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_final_result  (o_final_result),
        .o_decode_status (o_decode_status)
    );

    // Predictor state
    t_parse_phase         line_phase;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] data_left;
    logic                 cr_held;
    logic                 size_ovf;
    logic [1:0]           trailer_left;
    t_cbd_status          err_status;

    t_cbd_result decoded_outputs_due[$];
    logic [7:0]  body_q[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  bodies_sent = 0;
    int  payload_seen = 0;
    int  status_seen[3] = '{0, 0, 0};
    bit  calm = 1'b0;

    // Directed bodies: extension and payload extremes, no digits, truncation,
    // lone CR with short trailer, unfinished size line holding a sign.
    t_stim_row directed_rows [26] = '{
        '{" ",       1'b0, 1'b0, '0},
        '{"2",       1'b0, 1'b0, '0},
        '{";",       1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b0, 1'b0, '0},
        '{8'hFF,     1'b0, 1'b0, '0},
        '{8'h00,     1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b0, 1'b0, '0},
        '{"0",       1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}},
        '{"G",       1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b0, 1'b0, '0},
        '{"A",       1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_MALFORMED}},
        '{"3",       1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b0, 1'b0, '0},
        '{"a",       1'b1, 1'b1, '{"a", 1'b1, 1'b1, ST_TRUNCATED}},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{"1",       1'b0, 1'b0, '0},
        '{ASCII_CR,  1'b0, 1'b0, '0},
        '{ASCII_LF,  1'b0, 1'b0, '0},
        '{8'h80,     1'b1, 1'b1, '{8'h80, 1'b1, 1'b1, ST_OK}},
        '{"+",       1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}}
    };

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= !calm && ($urandom_range(99) < 10);
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_cbd_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_outputs_due.size() == 0) begin
                report_mismatch("result with nothing due", o_payload_byte, 8'h00);
            end else begin
                want = decoded_outputs_due.pop_front();
                if (o_payload_valid !== want.payload_valid)
                    report_mismatch("payload_valid", o_payload_valid, want.payload_valid);
                if (o_payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", o_payload_byte, want.payload_byte);
                if (o_final_result !== want.final_result)
                    report_mismatch("final_result", o_final_result, want.final_result);
                if (o_decode_status !== want.decode_status)
                    report_mismatch("decode_status", o_decode_status, want.decode_status);
                if (want.payload_valid)
                    payload_seen++;
                if (want.final_result)
                    status_seen[want.decode_status]++;
            end
        end
    end

    // ---------------- predictor ----------------

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == ASCII_SPACE || (c >= ASCII_HT && c <= ASCII_CR);
    endfunction

    function automatic void clear_decoder();
        line_phase = LINE_LEAD;
        size_acc = '0;
        data_left = '0;
        cr_held = 1'b0;
        size_ovf = 1'b0;
        trailer_left = 2'd0;
        err_status = ST_OK;
    endfunction

    function automatic void push_size_digit(input logic [3:0] d);
        if (size_ovf)
            return;
        // a nonzero top nibble means one more digit cannot fit
        if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            size_ovf = 1'b1;
            return;
        end
        size_acc = {size_acc[SIZE_BITS-5:0], d};
    endfunction

    function automatic void size_line_char(input logic [7:0] c);
        int nib;
        nib = hex_nibble(c);
        case (line_phase)
            LINE_LEAD: begin
                if (!is_blank(c)) begin
                    if (nib >= 0) begin
                        line_phase = LINE_SIZE;
                        push_size_digit(nib[3:0]);
                    end else begin
                        line_phase = LINE_JUNK;
                    end
                end
            end
            LINE_SIZE: begin
                if (nib >= 0)
                    push_size_digit(nib[3:0]);
                else
                    line_phase = LINE_EXT;
            end
            default: ;
        endcase
    endfunction

    function automatic void size_line_done();
        if (line_phase == LINE_LEAD || line_phase == LINE_JUNK || size_ovf) begin
            line_phase = BODY_BAD;
            err_status = ST_MALFORMED;
        end else if (size_acc == '0) begin
            line_phase = BODY_DONE;
        end else begin
            data_left = size_acc;
            line_phase = CHUNK_DATA;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic eob,
                                        output bit has_res, output t_cbd_result res,
                                        output bit ignored);
        bit emit;
        emit = 1'b0;
        ignored = (line_phase == BODY_DONE || line_phase == BODY_BAD);
        case (line_phase)
            LINE_LEAD, LINE_SIZE, LINE_EXT, LINE_JUNK: begin
                if (cr_held && c == ASCII_LF) begin
                    cr_held = 1'b0;
                    size_line_done();
                end else begin
                    // a CR that is not followed by LF is an ordinary line byte
                    if (cr_held)
                        size_line_char(ASCII_CR);
                    cr_held = (c == ASCII_CR);
                    if (!cr_held)
                        size_line_char(c);
                end
            end
            CHUNK_DATA: begin
                emit = 1'b1;
                data_left = data_left - 1'b1;
                if (data_left == '0) begin
                    line_phase = CHUNK_TRAILER;
                    trailer_left = 2'd2;
                end
            end
            CHUNK_TRAILER: begin
                if (trailer_left != 2'd0)
                    trailer_left = trailer_left - 2'd1;
                if (trailer_left == 2'd0) begin
                    line_phase = LINE_LEAD;
                    size_acc = '0;
                    size_ovf = 1'b0;
                    cr_held = 1'b0;
                end
            end
            default: ;
        endcase
        has_res = emit || eob;
        res.payload_byte = emit ? c : 8'h00;
        res.payload_valid = emit;
        res.final_result = eob;
        res.decode_status = ST_OK;
        if (eob) begin
            if (line_phase == BODY_BAD)
                res.decode_status = err_status;
            else if (line_phase == CHUNK_DATA && data_left != '0)
                res.decode_status = ST_TRUNCATED;
            clear_decoder();
        end
    endfunction

    // ---------------- body generation ----------------

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return "0" + 8'(n);
        base = $urandom_range(1) ? "A" : "a";
        return base + 8'(n) - 8'd10;
    endfunction

    function automatic void add_blanks();
        logic [7:0] pick [6];
        logic [7:0] c;
        pick = '{ASCII_SPACE, ASCII_HT, CH_VT, CH_FF, ASCII_LF, ASCII_CR};
        repeat ($urandom_range(1, 2)) begin
            c = pick[$urandom_range(5)];
            // keep CR LF from closing the line early
            if (c == ASCII_LF && body_q.size() != 0 && body_q[$] == ASCII_CR)
                c = ASCII_SPACE;
            body_q.push_back(c);
        end
    endfunction

    function automatic void add_extension();
        body_q.push_back(";");
        repeat ($urandom_range(0, 4))
            body_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        if ($urandom_range(3) == 0) begin
            body_q.push_back(ASCII_CR);
            body_q.push_back("x");
        end
    endfunction

    function automatic void add_size_line(input logic [SIZE_BITS-1:0] size);
        int digits;
        if ($urandom_range(4) == 0)
            add_blanks();
        digits = 1;
        for (int k = 1; k < SIZE_BITS / 4; k++)
            if ((size >> (4 * k)) != '0)
                digits = k + 1;
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 2)) body_q.push_back("0");
        for (int k = digits - 1; k >= 0; k--)
            body_q.push_back(hex_char(size[4 * k +: 4]));
        if ($urandom_range(4) == 0)
            add_extension();
        body_q.push_back(ASCII_CR);
        body_q.push_back(ASCII_LF);
    endfunction

    function automatic int pick_chunk_len();
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(1, 8);
        if (r < 98) return $urandom_range(9, 40);
        return $urandom_range(100, 255);
    endfunction

    function automatic void add_chunk(input int size);
        add_size_line(SIZE_BITS'(size));
        repeat (size) body_q.push_back(8'($urandom_range(255)));
        if ($urandom_range(9) != 0) begin
            body_q.push_back(ASCII_CR);
            body_q.push_back(ASCII_LF);
        end else begin
            repeat (2) body_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_last_chunk();
        if ($urandom_range(7) == 0) begin
            // hex prefix reads as size zero followed by junk
            body_q.push_back("0");
            body_q.push_back("x");
            body_q.push_back(hex_char(4'($urandom_range(15))));
            body_q.push_back(ASCII_CR);
            body_q.push_back(ASCII_LF);
        end else begin
            add_size_line('0);
        end
    endfunction

    function automatic void add_bad_line();
        logic [7:0] c;
        case ($urandom_range(2))
            0: begin
                if ($urandom_range(1) != 0)
                    add_blanks();
                do
                    c = 8'($urandom_range(8'h21, 8'h7E));
                while (hex_nibble(c) >= 0);
                body_q.push_back(c);
                repeat ($urandom_range(0, 3))
                    body_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            1: ;
            default: begin
                // more significant digits than the size counter holds
                body_q.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(SIZE_BITS / 4, SIZE_BITS / 4 + 2))
                    body_q.push_back(hex_char(4'($urandom_range(15))));
            end
        endcase
        body_q.push_back(ASCII_CR);
        body_q.push_back(ASCII_LF);
    endfunction

    function automatic void build_body();
        int kind;
        int keep;
        body_q.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(kind < 75 ? 1 : 0, 4))
            add_chunk(pick_chunk_len());
        if (kind < 75)
            add_last_chunk();
        else
            add_bad_line();
        repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(255)));
        // end the body early at a random byte
        if ($urandom_range(4) == 0) begin
            keep = $urandom_range(1, body_q.size());
            while (body_q.size() > keep)
                void'(body_q.pop_back());
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input logic [7:0] c, input logic eob, input logic typed,
                             input t_cbd_result want);
        bit          has_res;
        bit          ignored;
        t_cbd_result res;
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= c;
        i_end_of_body <= eob;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        decode_byte(c, eob, has_res, res, ignored);
        if (!ignored)
            items_sent++;
        if (eob)
            bodies_sent++;
        if (typed)
            decoded_outputs_due.push_back(want);
        else if (has_res)
            decoded_outputs_due.push_back(res);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_outputs_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        bit drained_mid;
        drained_mid = 1'b0;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].ch, directed_rows[r].eob, directed_rows[r].typed,
                      directed_rows[r].want);
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 300 && items_sent < 450);
            if (!drained_mid && items_sent >= 500) begin
                drained_mid = 1'b1;
                wait_drained();
            end
            build_body();
            foreach (body_q[k])
                send_item(body_q[k], k == body_q.size() - 1, 1'b0, '0);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d bodies, %0d decoded input items, %0d payload bytes out",
                 bodies_sent, items_sent, payload_seen);
        $display("body endings: %0d ok, %0d malformed size, %0d truncated chunk",
                 status_seen[ST_OK], status_seen[ST_MALFORMED], status_seen[ST_TRUNCATED]);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
